>>> src/ost_pkg.sv
// Shared types and constants for the ordered symbol table.
// Command and status codes, size defaults, controller command bundle.
`default_nettype none

package ost_pkg;

    localparam int unsigned DEPTH_DEF    = 32;
    localparam int unsigned KEY_BITS_DEF = 64;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned KEY_W    = 64;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned INDEX_W  = 5;
    localparam int unsigned FILL_W   = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_LOOKUP = 3'd2,
        CMD_RENAME = 3'd3,
        CMD_READDR = 3'd4,
        CMD_BOTH   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DUP      = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch input beat and match results
        logic execute;   // apply command to table, load result register
    } ost_ctl_t;

endpackage

`default_nettype wire

>>> src/ost_ctrl.sv
// Controller for the ordered symbol table: two-state sequencer plus
// output valid flag. Depends on ost_pkg.
`default_nettype none

module ost_ctrl
    import ost_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output ost_ctl_t      ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign ctl.capture = in_valid && in_ready;
    // result slot is free or drains this cycle
    assign ctl.execute = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ctl.capture)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (ctl.execute)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase

            if (ctl.execute)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> src/ost_datapath.sv
// Datapath for the ordered symbol table: a row of key/address cells with
// per-cell comparators, fill count, and the result register. Uses ost_pkg.
`default_nettype none

module ost_datapath
    import ost_pkg::*;
#(
    parameter int unsigned DEPTH    = DEPTH_DEF,
    parameter int unsigned KEY_BITS = KEY_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ost_ctl_t             ctl,
    input  wire logic [CMD_W-1:0]     cmd,
    input  wire logic [KEY_W-1:0]     key,
    input  wire logic [KEY_W-1:0]     new_key,
    input  wire logic [ADDR_W-1:0]    addr_in,
    output logic [STATUS_W-1:0]       status,
    output logic [INDEX_W-1:0]        index,
    output logic [ADDR_W-1:0]         addr_out,
    output logic [FILL_W-1:0]         fill
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    // table cells
    logic [KEY_BITS-1:0] key_cell_reg  [DEPTH];
    logic [ADDR_W-1:0]   addr_cell_reg [DEPTH];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    // latched command and match results
    logic [CMD_W-1:0]    cmd_reg;
    logic [KEY_BITS-1:0] nkey_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [DEPTH-1:0]    sel_reg;
    logic [IDX_W-1:0]    pos_reg;
    logic                found_reg;
    logic                nfound_reg;

    // result register
    logic [STATUS_W-1:0] status_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [ADDR_W-1:0]   aout_reg;
    logic [CNT_W-1:0]    fill_reg;

    // match stage
    logic [DEPTH-1:0]    hit_k;
    logic [DEPTH-1:0]    hit_n;
    logic [DEPTH-1:0]    first_k;
    logic [IDX_W-1:0]    pos_enc;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_k[i] = (CNT_W'(i) < count_reg) && (key_cell_reg[i] == key[KEY_BITS-1:0]);
            hit_n[i] = (CNT_W'(i) < count_reg) && (key_cell_reg[i] == new_key[KEY_BITS-1:0]);
        end
        first_k = hit_k & (~hit_k + DEPTH'(1));
        pos_enc = '0;
        for (int i = 0; i < DEPTH; i++)
            if (first_k[i])
                pos_enc = pos_enc | IDX_W'(i);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg    <= cmd;
            key_reg    <= key[KEY_BITS-1:0];
            nkey_reg   <= new_key[KEY_BITS-1:0];
            addr_reg   <= addr_in;
            sel_reg    <= first_k;
            pos_reg    <= pos_enc;
            found_reg  <= |hit_k;
            nfound_reg <= |hit_n;
        end
    end

    // execute stage
    logic [ADDR_W-1:0]   sel_addr;
    logic [DEPTH-1:0]    ge_mask;
    logic                ins_we;
    logic                del_we;
    logic                key_we;
    logic                adr_we;
    logic [STATUS_W-1:0] st_c;
    logic [IDX_W-1:0]    idx_c;
    logic [ADDR_W-1:0]   aout_c;

    always_comb
    begin
        sel_addr = '0;
        for (int i = 0; i < DEPTH; i++)
            if (sel_reg[i])
                sel_addr = sel_addr | addr_cell_reg[i];
    end

    // cells at and above the matched one
    assign ge_mask = ~(sel_reg - DEPTH'(1));

    always_comb
    begin
        st_c       = ST_OK;
        idx_c      = '0;
        aout_c     = '0;
        ins_we     = 1'b0;
        del_we     = 1'b0;
        key_we     = 1'b0;
        adr_we     = 1'b0;
        count_next = count_reg;
        if (cmd_reg == CMD_INSERT)
        begin
            if (found_reg)
            begin
                st_c   = ST_DUP;
                idx_c  = pos_reg;
                aout_c = sel_addr;
            end
            else if (count_reg >= CNT_W'(DEPTH))
                st_c = ST_FULL;
            else
            begin
                ins_we     = 1'b1;
                idx_c      = count_reg[IDX_W-1:0];
                aout_c     = addr_reg;
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (!found_reg)
            st_c = ST_NOTFOUND;
        else
        begin
            idx_c  = pos_reg;
            aout_c = sel_addr;
            priority if (cmd_reg == CMD_DELETE)
            begin
                del_we     = 1'b1;
                count_next = count_reg - CNT_W'(1);
            end
            else if (cmd_reg == CMD_RENAME || cmd_reg == CMD_READDR || cmd_reg == CMD_BOTH)
            begin
                if (cmd_reg != CMD_READDR && nfound_reg)
                    st_c = ST_DUP;
                else
                begin
                    key_we = (cmd_reg != CMD_READDR);
                    adr_we = (cmd_reg != CMD_RENAME);
                    if (adr_we)
                        aout_c = addr_reg;
                end
            end
            else
            begin
                // lookup and unused codes
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (ctl.execute)
            begin
                if (ins_we && count_reg[IDX_W-1:0] == IDX_W'(g))
                begin
                    key_cell_reg[g]  <= key_reg;
                    addr_cell_reg[g] <= addr_reg;
                end
                else if (del_we && ge_mask[g])
                begin
                    if (g < DEPTH - 1)
                    begin
                        key_cell_reg[g]  <= key_cell_reg[(g + 1) % DEPTH];
                        addr_cell_reg[g] <= addr_cell_reg[(g + 1) % DEPTH];
                    end
                end
                else if (sel_reg[g])
                begin
                    if (key_we)
                        key_cell_reg[g] <= nkey_reg;
                    if (adr_we)
                        addr_cell_reg[g] <= addr_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctl.execute)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.execute)
        begin
            status_reg <= st_c;
            idx_reg    <= idx_c;
            aout_reg   <= aout_c;
            fill_reg   <= count_next;
        end
    end

    // zero-extend then trim to the fixed result widths
    logic [IDX_W+INDEX_W-1:0] idx_wide;
    logic [CNT_W+FILL_W-1:0]  fill_wide;

    assign idx_wide  = {{INDEX_W{1'b0}}, idx_reg};
    assign fill_wide = {{FILL_W{1'b0}}, fill_reg};
    assign status    = status_reg;
    assign index     = idx_wide[INDEX_W-1:0];
    assign addr_out  = aout_reg;
    assign fill      = fill_wide[FILL_W-1:0];

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.execute |-> $onehot0(sel_reg))
        else $error("more than one selected cell");

    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.execute && cmd_reg == CMD_DELETE && found_reg)
            |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not shrink table");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.execute && cmd_reg == CMD_INSERT && !found_reg && count_reg < CNT_W'(DEPTH))
            |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow table");

endmodule

`default_nettype wire

>>> src/ordered_symbol_table_unit.sv
// Each command is matched, then executed, before its result beat is loaded.
// A new command is taken only after the previous one has executed, due to the
// match-then-update loop over the cells: each sees the table the last one left.
// A new input beat is taken while an earlier result still waits downstream.
// Reset (rst_n, async, active low) empties the table, clears out_valid and
// idles the sequencer; cells are not cleared and are never read before being written.
`default_nettype none

module ordered_symbol_table_unit
    import ost_pkg::*;
#(
    parameter int unsigned DEPTH    = DEPTH_DEF,
    parameter int unsigned KEY_BITS = KEY_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // command beat
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CMD_W-1:0]     cmd,
    input  wire logic [KEY_W-1:0]     key,
    input  wire logic [KEY_W-1:0]     new_key,
    input  wire logic [ADDR_W-1:0]    addr_in,
    // result beat
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [STATUS_W-1:0]       status,
    output logic [INDEX_W-1:0]        index,
    output logic [ADDR_W-1:0]         addr_out,
    output logic [FILL_W-1:0]         fill
);

    ost_ctl_t ctl;

    // Sequencer: IDLE takes a beat and latches compare results from every
    // cell; EXEC applies insert/delete/modify and loads the result register,
    // holding off only while the previous result has not drained.
    ost_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    // Cell row: per-cell key compare, delete shifts upper cells down by one,
    // writes land on the matched cell or at the fill position.
    ost_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .cmd      (cmd),
        .key      (key),
        .new_key  (new_key),
        .addr_in  (addr_in),
        .status   (status),
        .index    (index),
        .addr_out (addr_out),
        .fill     (fill)
    );

endmodule

`default_nettype wire

>>> tb/ost_result_checker.sv
// Result checker for the ordered symbol table: keeps its own copy of the table,
// predicts one outcome per command beat and compares it with each result beat.
// Depends on ost_pkg for widths, command codes and status codes.

module ost_result_checker
    import ost_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [KEY_W-1:0]    key,
    input  logic [KEY_W-1:0]    new_key,
    input  logic [ADDR_W-1:0]   addr_in,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [STATUS_W-1:0] status,
    input  logic [INDEX_W-1:0]  index,
    input  logic [ADDR_W-1:0]   addr_out,
    input  logic [FILL_W-1:0]   fill,
    output int                  fail_count,
    output int                  outstanding
);

    localparam int unsigned SLOTS = DEPTH_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [ADDR_W-1:0]   addr;
        logic [FILL_W-1:0]   fill;
    } outcome_t;

    logic [KEY_W-1:0]  slot_key  [SLOTS];
    logic [ADDR_W-1:0] slot_addr [SLOTS];
    int                used_slots;
    outcome_t          awaited_outcomes [$];
    int                mismatches;

    // first slot holding k, or SLOTS when absent
    function automatic int find_slot(logic [KEY_W-1:0] k);
        for (int i = 0; i < used_slots; i++)
            if (slot_key[i] == k)
                return i;
        return SLOTS;
    endfunction

    function automatic outcome_t apply_table_cmd(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                                 logic [KEY_W-1:0] nk, logic [ADDR_W-1:0] a);
        outcome_t res;
        int       pos;
        pos = find_slot(k);
        res = '0;
        res.status = ST_OK;
        if (c == CMD_INSERT) begin
            if (pos < SLOTS) begin
                res.status = ST_DUP;
                res.index  = pos[INDEX_W-1:0];
                res.addr   = slot_addr[pos];
            end else if (used_slots >= SLOTS) begin
                res.status = ST_FULL;
            end else begin
                res.index             = used_slots[INDEX_W-1:0];
                slot_key[used_slots]  = k;
                slot_addr[used_slots] = a;
                res.addr              = a;
                used_slots++;
            end
        end else if (pos >= SLOTS) begin
            res.status = ST_NOTFOUND;
        end else if (c == CMD_DELETE) begin
            res.index = pos[INDEX_W-1:0];
            res.addr  = slot_addr[pos];
            for (int i = pos; i + 1 < used_slots; i++) begin
                slot_key[i]  = slot_key[i+1];
                slot_addr[i] = slot_addr[i+1];
            end
            used_slots--;
        end else if (c == CMD_RENAME || c == CMD_READDR || c == CMD_BOTH) begin
            res.index = pos[INDEX_W-1:0];
            if (c != CMD_READDR && find_slot(nk) < SLOTS) begin
                res.status = ST_DUP;   // rename refused, address left alone too
            end else begin
                if (c != CMD_READDR)
                    slot_key[pos] = nk;
                if (c != CMD_RENAME)
                    slot_addr[pos] = a;
            end
            res.addr = slot_addr[pos];
        end else begin
            // lookup and the spare codes
            res.index = pos[INDEX_W-1:0];
            res.addr  = slot_addr[pos];
        end
        res.fill = used_slots[FILL_W-1:0];
        return res;
    endfunction

    function automatic void note_mismatch(string what, outcome_t want, outcome_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected status %0d index %0d addr %h fill %0d, got status %0d index %0d addr %h fill %0d",
                     $time, what, want.status, want.index, want.addr, want.fill,
                     got.status, got.index, got.addr, got.fill);
    endfunction

    initial
    begin
        mismatches  = 0;
        used_slots  = 0;
        fail_count  = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n) begin
            used_slots = 0;
            awaited_outcomes.delete();
        end else begin
            if (in_valid && in_ready)
                awaited_outcomes.push_back(apply_table_cmd(cmd, key, new_key, addr_in));
            if (out_valid && out_ready) begin
                got = '{status, index, addr_out, fill};
                if (awaited_outcomes.size() == 0) begin
                    note_mismatch("result beat with nothing awaited", '0, got);
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (got.status !== want.status || got.index !== want.index ||
                        got.addr !== want.addr || got.fill !== want.fill)
                        note_mismatch("result mismatch", want, got);
                end
            end
        end
        outstanding <= awaited_outcomes.size();
        fail_count  <= mismatches;
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for ordered_symbol_table_unit: clock, reset, command stimulus,
// result-side stalls, watchdog and verdict. Depends on ost_pkg and ost_result_checker.

module tb_top
    import ost_pkg::*;
();

    // spare command codes, answered like a lookup
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int POOL_SIZE    = 48;   // more labels than slots so the table can fill
    localparam int RANDOM_BEATS = 550;
    localparam int PHASE_LEN    = 40;
    localparam int IDLE_LIMIT   = 1000; // longest legal quiet stretch is the result-side hold-off
    localparam int HOLDOFF_AT   = 400;
    localparam int HOLDOFF_LEN  = 150;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} stim_phase_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [CMD_W-1:0]    cmd;
    logic [KEY_W-1:0]    key;
    logic [KEY_W-1:0]    new_key;
    logic [ADDR_W-1:0]   addr_in;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
    logic [ADDR_W-1:0]   addr_out;
    logic [FILL_W-1:0]   fill;

    int                  fail_count;
    int                  outstanding;
    int                  idle_cycles;
    int                  burst_left;
    int                  insert_ptr;
    logic [KEY_W-1:0]    label_pool [POOL_SIZE];

    // 12-unit clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    ordered_symbol_table_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .key       (key),
        .new_key   (new_key),
        .addr_in   (addr_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .index     (index),
        .addr_out  (addr_out),
        .fill      (fill)
    );

    ost_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .key         (key),
        .new_key     (new_key),
        .addr_in     (addr_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .index       (index),
        .addr_out    (addr_out),
        .fill        (fill),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic logic [KEY_W-1:0] rand_label();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KEY_W-1:0] pool_label();
        return label_pool[$urandom_range(0, POOL_SIZE-1)];
    endfunction

    // mostly labels that may be present, some fresh ones that will miss
    function automatic logic [KEY_W-1:0] search_label();
        return ($urandom_range(0, 99) < 88) ? pool_label() : rand_label();
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return {1'b1, {(ADDR_W-1){1'b0}}};
        if (pick == 1)
            return {1'b0, {(ADDR_W-1){1'b1}}};
        if (pick == 2)
            return '1;
        return $urandom;
    endfunction

    // command mix per phase: fill grows the table to full, drain shrinks it
    function automatic logic [CMD_W-1:0] pick_cmd(stim_phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
                if (r < 80)      return CMD_INSERT;
                else if (r < 88) return CMD_LOOKUP;
                else if (r < 94) return CMD_READDR;
                else             return CMD_RENAME;
            PH_DRAIN:
                if (r < 50)      return CMD_DELETE;
                else if (r < 65) return CMD_LOOKUP;
                else if (r < 75) return CMD_INSERT;
                else if (r < 83) return CMD_RENAME;
                else if (r < 91) return CMD_READDR;
                else             return CMD_BOTH;
            default:
                if (r < 25)      return CMD_INSERT;
                else if (r < 40) return CMD_DELETE;
                else if (r < 52) return CMD_LOOKUP;
                else if (r < 66) return CMD_RENAME;
                else if (r < 78) return CMD_READDR;
                else if (r < 92) return CMD_BOTH;
                else if (r < 96) return CMD_SPARE_A;
                else             return CMD_SPARE_B;
        endcase
    endfunction

    // Present one command beat. Between beats the sender may drop valid for a
    // random gap; inside a burst valid stays high from beat to beat.
    task automatic send_cmd(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                            logic [KEY_W-1:0] nk, logic [ADDR_W-1:0] a);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // now and then a long burst with no sender idling at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= c;
        key      <= k;
        new_key  <= nk;
        addr_in  <= a;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Watchdog: any cycle without an accepted beat on either channel counts up.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: stall patterns drawn afresh for each random span, plus one
    // long hold-off so that the block backs up and drops in_ready while the
    // sender keeps offering beats.
    initial
    begin
        int mode;
        int span;
        int cyc;
        out_ready <= 1'b0;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 60);
            repeat (span)
            begin
                @(posedge clk);
                cyc++;
                if (cyc == HOLDOFF_AT) begin
                    out_ready <= 1'b0;
                    repeat (HOLDOFF_LEN) @(posedge clk);
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 99) < 55);
                    2:       out_ready <= (cyc % 4 != 3);
                    default: out_ready <= ($urandom_range(0, 99) < 15);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [KEY_W-1:0] k_zero;
        logic [KEY_W-1:0] k_ones;
        logic [KEY_W-1:0] k_edge;
        logic [KEY_W-1:0] k_alt;
        logic [KEY_W-1:0] k_miss;
        logic [CMD_W-1:0] c;
        logic [KEY_W-1:0] k;
        stim_phase_t      ph;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        cmd         <= CMD_LOOKUP;
        key         <= '0;
        new_key     <= '0;
        addr_in     <= '0;
        idle_cycles <= 0;
        burst_left  = 0;
        insert_ptr  = 0;

        // label pool with the extremes at the front
        label_pool[0] = '0;
        label_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            label_pool[i] = rand_label();

        k_zero = '0;
        k_ones = '1;
        k_edge = {1'b1, {(KEY_W-2){1'b0}}, 1'b1};
        k_alt  = {(KEY_W/2){2'b01}};
        k_miss = {(KEY_W/2){2'b10}};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicates, refused renames,
        // spare codes, deletes that shift and that empty the table
        send_cmd(CMD_LOOKUP, k_zero, k_zero, '0);                  // miss on empty
        send_cmd(CMD_DELETE, k_zero, k_zero, '0);                  // miss on empty
        send_cmd(CMD_INSERT, k_zero, k_ones, 32'h8000_0000);
        send_cmd(CMD_INSERT, k_ones, k_zero, 32'h7fff_ffff);
        send_cmd(CMD_INSERT, k_zero, k_zero, 32'h0000_0001);       // duplicate
        send_cmd(CMD_INSERT, k_edge, k_zero, 32'hffff_ffff);
        send_cmd(CMD_LOOKUP, k_ones, k_zero, '0);
        send_cmd(CMD_RENAME, k_ones, k_ones, '0);                  // own name, refused
        send_cmd(CMD_RENAME, k_ones, k_zero, '0);                  // taken name, refused
        send_cmd(CMD_RENAME, k_ones, k_alt, '0);
        send_cmd(CMD_READDR, k_alt, k_zero, 32'h0000_0000);
        send_cmd(CMD_BOTH, k_alt, k_ones, 32'h1234_5678);
        send_cmd(CMD_BOTH, k_ones, k_edge, 32'h0000_0005);         // refused, addr kept
        send_cmd(CMD_SPARE_A, k_edge, k_zero, '0);
        send_cmd(CMD_SPARE_B, k_miss, k_zero, '0);
        send_cmd(CMD_READDR, k_miss, k_zero, 32'hdead_beef);       // miss
        send_cmd(CMD_RENAME, k_miss, k_alt, '0);                   // miss
        send_cmd(CMD_BOTH, k_miss, k_alt, 32'h0bad_f00d);          // miss
        send_cmd(CMD_DELETE, k_zero, k_zero, '0);                  // first entry, shifts
        send_cmd(CMD_LOOKUP, k_edge, k_zero, '0);
        send_cmd(CMD_DELETE, k_edge, k_zero, '0);                  // last entry
        send_cmd(CMD_INSERT, k_alt, k_zero, 32'haaaa_aaaa);
        send_cmd(CMD_DELETE, k_ones, k_zero, '0);
        send_cmd(CMD_DELETE, k_alt, k_zero, '0);                   // table empty again

        // random: phases of fill, drain and mixed traffic; fill walks the pool
        // in order so the table reaches full and then refuses inserts
        ph = PH_FILL;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n > 0 && n % PHASE_LEN == 0)
                ph = stim_phase_t'($urandom_range(0, 2));
            c = pick_cmd(ph);
            if (c == CMD_INSERT && ph == PH_FILL) begin
                k = label_pool[insert_ptr];
                insert_ptr = (insert_ptr + 1) % POOL_SIZE;
            end else begin
                k = search_label();
            end
            send_cmd(c, k, ($urandom_range(0, 1) == 0) ? pool_label() : rand_label(),
                     rand_addr());
        end
        in_valid <= 1'b0;

        // let the count include the last beat, then drain every awaited result
        // and let the match-then-execute pipe settle
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
